>>> design/s4a_pkg.sv
// Shared types and constants of the SOCKS4/4a request parser.
package s4a_pkg;

  // Command codes of a SOCKS4 request
  localparam logic [7:0] CMD_CONNECT = 8'h01;
  localparam logic [7:0] CMD_BIND    = 8'h02;

  // Request layout
  localparam int unsigned USERID_OFFSET     = 8;
  localparam int unsigned MIN_REQUEST_BYTES = 9;

  // Verdict codes as they leave the block
  typedef enum logic [1:0] {
    VERDICT_GRANTED   = 2'd0,
    VERDICT_BIND      = 2'd1,
    VERDICT_NO_USERID = 2'd2,
    VERDICT_MALFORMED = 2'd3
  } verdict_t;

  // Control and status of the byte just parsed, passed to the verdict stage
  typedef struct packed {
    logic       valid;
    logic       last;
    logic       byte_zero;
    logic       overflow;
    logic [1:0] zero_count;
    logic [7:0] command;
  } parse_status_t;

endpackage

>>> design/s4a_parse.sv
// Input register and running parse state of the SOCKS4/4a request parser.
module s4a_parse import s4a_pkg::*; #(
  parameter int unsigned MAX_REQUEST_BYTES = 256,
  parameter int unsigned POS_W             = $clog2(MAX_REQUEST_BYTES + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,
  input  logic               in_tlast,
  input  logic               advance,
  output parse_status_t      status,
  output logic [POS_W-1:0]   pos_out,
  output logic [POS_W-1:0]   first_zero_out,
  output logic [POS_W-1:0]   second_zero_out,
  output logic [15:0]        port_out,
  output logic [31:0]        addr_out
);

  localparam logic [POS_W-1:0] POS_MAX    = POS_W'(MAX_REQUEST_BYTES);
  localparam logic [POS_W-1:0] POS_USERID = POS_W'(USERID_OFFSET);

  logic             in_valid_r;
  logic [7:0]       in_byte_r;
  logic             in_last_r;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       cmd_r, cmd_nxt;
  logic [15:0]      port_r, port_nxt;
  logic [31:0]      addr_r, addr_nxt;
  logic [1:0]       zc_r, zc_nxt;
  logic [POS_W-1:0] fz_r, fz_nxt;
  logic [POS_W-1:0] sz_r, sz_nxt;
  logic             ovf_r, ovf_nxt;

  logic             step;

  assign in_tready = !in_valid_r || advance;
  assign step      = in_valid_r && advance;

  // Hold the incoming item until the verdict stage takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  // Fold the held byte into the parse state
  always_comb begin
    pos_nxt  = pos_r;
    cmd_nxt  = cmd_r;
    port_nxt = port_r;
    addr_nxt = addr_r;
    zc_nxt   = zc_r;
    fz_nxt   = fz_r;
    sz_nxt   = sz_r;
    ovf_nxt  = ovf_r;
    if (pos_r >= POS_MAX) begin
      ovf_nxt = 1'b1;
    end else begin
      pos_nxt = pos_r + POS_W'(1);
      priority if (pos_r == POS_W'(1)) begin
        cmd_nxt = in_byte_r;
      end else if (pos_r == POS_W'(2) || pos_r == POS_W'(3)) begin
        port_nxt = {port_r[7:0], in_byte_r};
      end else if (pos_r >= POS_W'(4) && pos_r <= POS_W'(7)) begin
        addr_nxt = {addr_r[23:0], in_byte_r};
      end else if (pos_r >= POS_USERID && in_byte_r == 8'h00) begin
        if (zc_r == 2'd0) begin
          fz_nxt = pos_r;
        end else if (zc_r == 2'd1) begin
          sz_nxt = pos_r;
        end
        if (zc_r != 2'd3) begin
          zc_nxt = zc_r + 2'd1;
        end
      end else begin
        cmd_nxt = cmd_r;
      end
    end
  end

  // Advance the state; clear it after the last byte of a request
  always_ff @(posedge clk) begin
    if (!rst_n || (step && in_last_r)) begin
      pos_r  <= '0;
      cmd_r  <= '0;
      port_r <= '0;
      addr_r <= '0;
      zc_r   <= '0;
      fz_r   <= '0;
      sz_r   <= '0;
      ovf_r  <= 1'b0;
    end else if (step) begin
      pos_r  <= pos_nxt;
      cmd_r  <= cmd_nxt;
      port_r <= port_nxt;
      addr_r <= addr_nxt;
      zc_r   <= zc_nxt;
      fz_r   <= fz_nxt;
      sz_r   <= sz_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

  // Present the state as it stands after this byte
  always_comb begin
    status.valid      = in_valid_r;
    status.last       = in_last_r;
    status.byte_zero  = (in_byte_r == 8'h00);
    status.overflow   = ovf_nxt;
    status.zero_count = zc_nxt;
    status.command    = cmd_nxt;
  end

  assign pos_out         = pos_nxt;
  assign first_zero_out  = fz_nxt;
  assign second_zero_out = sz_nxt;
  assign port_out        = port_nxt;
  assign addr_out        = addr_nxt;

`ifndef SYNTHESIS
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_MAX)
    else $error("byte position beyond buffer size");

  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> pos_r == POS_MAX)
    else $error("overflow flagged before position saturated");

  a_zero_order: assert property (@(posedge clk) disable iff (!rst_n)
    zc_r >= 2'd2 |-> sz_r > fz_r)
    else $error("second zero not after first zero");
`endif

endmodule

>>> design/s4a_verdict.sv
// Verdict logic and result register of the SOCKS4/4a request parser.
module s4a_verdict import s4a_pkg::*; #(
  parameter int unsigned POS_W = 9
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               auth_required,
  input  parse_status_t      status,
  input  logic [POS_W-1:0]   pos_in,
  input  logic [POS_W-1:0]   first_zero_in,
  input  logic [POS_W-1:0]   second_zero_in,
  input  logic [15:0]        port_in,
  input  logic [31:0]        addr_in,
  output logic               advance,
  output logic               out_tvalid,
  input  logic               out_tready,
  output verdict_t           verdict,
  output logic               is_socks4a,
  output logic [15:0]        dest_port,
  output logic [31:0]        dest_ip,
  output logic [7:0]         userid_length,
  output logic [7:0]         hostname_length
);

  localparam int unsigned EXT_W = POS_W + 8;

  logic             out_valid_r;
  verdict_t         verdict_r, verdict_nxt;
  logic             is4a_r, is4a_nxt;
  logic [15:0]      port_r;
  logic [31:0]      ip_r;
  logic [7:0]       ulen_r, ulen_nxt;
  logic [7:0]       hlen_r, hlen_nxt;

  logic [POS_W-1:0] zero_gap;
  logic [POS_W-1:0] ulen_raw;
  logic [POS_W-1:0] hlen_raw;
  logic [EXT_W-1:0] ulen_ext;
  logic [EXT_W-1:0] hlen_ext;
  logic             bad;

  assign advance = !out_valid_r || out_tready;

  // Judge the request from the state after its last byte
  always_comb begin
    is4a_nxt = (addr_in[31:8] == 24'd0) && (addr_in[7:0] != 8'd0);
    zero_gap = second_zero_in - first_zero_in;
    ulen_raw = first_zero_in - POS_W'(USERID_OFFSET);
    hlen_raw = zero_gap - POS_W'(1);
    ulen_ext = EXT_W'(ulen_raw);
    hlen_ext = EXT_W'(hlen_raw);

    bad = status.overflow || (pos_in < POS_W'(MIN_REQUEST_BYTES)) || !status.byte_zero;
    if (!bad) begin
      if (is4a_nxt) begin
        bad = (status.zero_count != 2'd2) || (zero_gap < POS_W'(2));
      end else begin
        bad = (status.zero_count != 2'd1);
      end
    end

    ulen_nxt    = (ulen_ext > EXT_W'(255)) ? 8'hFF : ulen_ext[7:0];
    hlen_nxt    = (is4a_nxt) ? ((hlen_ext > EXT_W'(255)) ? 8'hFF : hlen_ext[7:0]) : 8'd0;
    verdict_nxt = VERDICT_MALFORMED;
    priority if (bad) begin
      verdict_nxt = VERDICT_MALFORMED;
    end else if (auth_required && first_zero_in == POS_W'(USERID_OFFSET)) begin
      verdict_nxt = VERDICT_NO_USERID;
    end else if (status.command == CMD_CONNECT) begin
      verdict_nxt = VERDICT_GRANTED;
    end else if (status.command == CMD_BIND) begin
      verdict_nxt = VERDICT_BIND;
    end else begin
      verdict_nxt = VERDICT_MALFORMED;
    end
    if (verdict_nxt == VERDICT_MALFORMED) begin
      ulen_nxt = 8'd0;
      hlen_nxt = 8'd0;
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= status.valid && status.last;
    end
    if (advance && status.valid && status.last) begin
      verdict_r <= verdict_nxt;
      is4a_r    <= is4a_nxt;
      port_r    <= port_in;
      ip_r      <= addr_in;
      ulen_r    <= ulen_nxt;
      hlen_r    <= hlen_nxt;
    end
  end

  assign out_tvalid      = out_valid_r;
  assign verdict         = verdict_r;
  assign is_socks4a      = is4a_r;
  assign dest_port       = port_r;
  assign dest_ip         = ip_r;
  assign userid_length   = ulen_r;
  assign hostname_length = hlen_r;

`ifndef SYNTHESIS
  a_malformed_lens: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && verdict_r == VERDICT_MALFORMED |-> ulen_r == 8'd0 && hlen_r == 8'd0)
    else $error("malformed result carries lengths");

  a_host_needs_4a: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && hlen_r != 8'd0 |-> is4a_r)
    else $error("hostname length on plain SOCKS4 request");

  a_no_userid_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && verdict_r == VERDICT_NO_USERID |-> ulen_r == 8'd0)
    else $error("missing userid verdict with nonzero userid length");
`endif

endmodule

>>> design/socks4a_request_parser_unit.sv
// Top level of the SOCKS4/4a request parser: channels, configuration register, stages.
//
// Usage:
//   in_*  : one request byte per item in in_tdata[7:0]; in_tlast marks the final
//           byte of the request.
//   out_* : one result item per request, issued for the item carrying in_tlast.
//   cfg_* : cfg_wr_en writes cfg_wr_data into auth_required; write only while idle.
// Timing: one item per cycle sustained while out_tready does not stall the result
//   register. A byte sits in the input register, where the parse state is updated;
//   the verdict for the last byte of a request is then registered, and the result
//   register presents it on out_*. The path runs through these two registers.
// Reset (rst_n low, synchronous): parse state cleared, no result pending,
//   auth_required cleared.
// Stall: while out_tready is low a held result stays on out_*; the input register
//   takes at most one more byte, after which in_tready falls until the result goes.
// Requests longer than MAX_REQUEST_BYTES bytes are marked malformed; the extra
//   bytes are dropped.
module socks4a_request_parser_unit import s4a_pkg::*; #(
  parameter int unsigned MAX_REQUEST_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // Request bytes
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // end_of_request
  // Results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [1:0] verdict, [2] is_socks4a, [18:3] dest_port,
                                  // [50:19] dest_ip, [58:51] userid_length,
                                  // [66:59] hostname_length, [71:67] zero
  // Configuration
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data
);

  localparam int unsigned POS_W = $clog2(MAX_REQUEST_BYTES + 1);

  logic             auth_r;
  logic             advance;
  parse_status_t    status;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] first_zero;
  logic [POS_W-1:0] second_zero;
  logic [15:0]      port;
  logic [31:0]      addr;

  verdict_t         verdict;
  logic             is_socks4a;
  logic [15:0]      dest_port;
  logic [31:0]      dest_ip;
  logic [7:0]       userid_length;
  logic [7:0]       hostname_length;

  // Hold the auth setting
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auth_r <= 1'b0;
    end else if (cfg_wr_en) begin
      auth_r <= cfg_wr_data;
    end
  end

  s4a_parse #(
    .MAX_REQUEST_BYTES (MAX_REQUEST_BYTES),
    .POS_W             (POS_W)
  ) u_parse (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tlast        (in_tlast),
    .advance         (advance),
    .status          (status),
    .pos_out         (pos),
    .first_zero_out  (first_zero),
    .second_zero_out (second_zero),
    .port_out        (port),
    .addr_out        (addr)
  );

  s4a_verdict #(
    .POS_W (POS_W)
  ) u_verdict (
    .clk             (clk),
    .rst_n           (rst_n),
    .auth_required   (auth_r),
    .status          (status),
    .pos_in          (pos),
    .first_zero_in   (first_zero),
    .second_zero_in  (second_zero),
    .port_in         (port),
    .addr_in         (addr),
    .advance         (advance),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .verdict         (verdict),
    .is_socks4a      (is_socks4a),
    .dest_port       (dest_port),
    .dest_ip         (dest_ip),
    .userid_length   (userid_length),
    .hostname_length (hostname_length)
  );

  // Pack the result item
  assign out_tdata = {5'd0, hostname_length, userid_length, dest_ip, dest_port,
                      is_socks4a, verdict};

endmodule

>>> sim/socks4a_request_parser_unit_tb.sv
// Self-checking testbench of the SOCKS4/4a request parser: directed and random requests, scoreboard.
module socks4a_request_parser_unit_tb;
  import s4a_pkg::*;

  localparam int unsigned MAX_BYTES   = 256;
  localparam int          LATENCY_PAD = 4;

  // One request byte as it waits for the driver
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } req_byte_t;

  // Result item, laid out as on out_tdata (first member is the top)
  typedef struct packed {
    logic [4:0]  pad;
    logic [7:0]  host_len;
    logic [7:0]  user_len;
    logic [31:0] addr;
    logic [15:0] port;
    logic        is4a;
    verdict_t    verdict;
  } socks_reply_t;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = '0;
  logic        in_tlast    = 1'b0;
  logic        out_tvalid;
  logic        out_tready  = 1'b1;
  logic [71:0] out_tdata;
  logic        cfg_wr_en   = 1'b0;
  logic        cfg_wr_data = 1'b0;

  req_byte_t    request_bytes_q[$];
  socks_reply_t replies_due[$];
  logic [7:0]   build_q[$];
  int           error_count = 0;

  // Parser state of the prediction
  logic        auth_on     = 1'b0;
  int          rx_pos      = 0;
  logic [7:0]  rx_cmd      = '0;
  logic [15:0] rx_port     = '0;
  logic [31:0] rx_addr     = '0;
  int          rx_zeros    = 0;
  int          zero_pos_a  = 0;
  int          zero_pos_b  = 0;
  logic        rx_overflow = 1'b0;

  // Handshake pacing
  int   in_gap   = 0;
  int   out_hold = 0;
  logic drv_calm = 1'b0;
  logic mon_calm = 1'b0;

  socks4a_request_parser_unit #(
    .MAX_REQUEST_BYTES(MAX_BYTES)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Gap length: mostly none or short, now and then long
  function automatic int pick_gap(input logic calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Advance the parse by one byte; return 1 with the verdict on the final byte
  function automatic bit parse_request_byte(input logic [7:0] b, input logic last,
                                            output socks_reply_t rep);
    bit       is4a;
    bit       bad;
    int       ulen;
    int       hlen;
    verdict_t v;
    rep  = '0;
    ulen = 0;
    hlen = 0;
    // Capture header fields and track zeros from the userid on
    if (rx_pos >= MAX_BYTES) begin
      rx_overflow = 1'b1;
    end else begin
      if (rx_pos == 1) begin
        rx_cmd = b;
      end else if (rx_pos == 2 || rx_pos == 3) begin
        rx_port = {rx_port[7:0], b};
      end else if (rx_pos >= 4 && rx_pos <= 7) begin
        rx_addr = {rx_addr[23:0], b};
      end else if (rx_pos >= USERID_OFFSET && b == 8'h00) begin
        if (rx_zeros == 0) zero_pos_a = rx_pos;
        else if (rx_zeros == 1) zero_pos_b = rx_pos;
        if (rx_zeros < 3) rx_zeros++;
      end
      rx_pos++;
    end
    if (!last) return 1'b0;

    // Decide the verdict in priority order
    is4a = (rx_addr[31:8] == 24'h0) && (rx_addr[7:0] != 8'h00);
    bad  = rx_overflow || rx_pos < MIN_REQUEST_BYTES || b != 8'h00;
    if (!bad) begin
      if (is4a) bad = rx_zeros != 2 || (zero_pos_b - zero_pos_a) < 2;
      else      bad = rx_zeros != 1;
    end
    if (bad) begin
      v = VERDICT_MALFORMED;
    end else begin
      ulen = zero_pos_a - USERID_OFFSET;
      if (is4a) hlen = zero_pos_b - zero_pos_a - 1;
      if (auth_on && zero_pos_a <= USERID_OFFSET) begin
        v = VERDICT_NO_USERID;
      end else if (rx_cmd == CMD_CONNECT) begin
        v = VERDICT_GRANTED;
      end else if (rx_cmd == CMD_BIND) begin
        v = VERDICT_BIND;
      end else begin
        v    = VERDICT_MALFORMED;
        ulen = 0;
        hlen = 0;
      end
    end
    rep.verdict  = v;
    rep.is4a     = is4a;
    rep.port     = rx_port;
    rep.addr     = rx_addr;
    rep.user_len = (ulen > 255) ? 8'd255 : 8'(ulen);
    rep.host_len = (hlen > 255) ? 8'd255 : 8'(hlen);

    // Clear the parse for the next request
    rx_pos      = 0;
    rx_cmd      = '0;
    rx_port     = '0;
    rx_addr     = '0;
    rx_zeros    = 0;
    zero_pos_a  = 0;
    zero_pos_b  = 0;
    rx_overflow = 1'b0;
    return 1'b1;
  endfunction

  // Drive request bytes; predict each accepted item
  always @(posedge clk) begin : drive_bytes
    req_byte_t    nxt;
    socks_reply_t rep;
    logic         fire;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tlast  <= 1'b0;
    end else begin
      fire = in_tvalid && in_tready;
      if (fire) begin
        if (parse_request_byte(in_tdata, in_tlast, rep)) replies_due.push_back(rep);
        in_gap = pick_gap(drv_calm);
        if ($urandom_range(0, 63) == 0) drv_calm = !drv_calm;
      end
      if (fire || !in_tvalid) begin
        if (in_gap == 0 && request_bytes_q.size() > 0) begin
          nxt = request_bytes_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= nxt.data;
          in_tlast  <= nxt.last;
        end else begin
          if (in_gap > 0) in_gap--;
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Compare each result item with the oldest expectation; pace out_tready
  always @(posedge clk) begin : check_replies
    socks_reply_t got;
    socks_reply_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = socks_reply_t'(out_tdata);
        if (replies_due.size() == 0) begin
          $error("unexpected result item: tdata %h", out_tdata);
          error_count++;
        end else begin
          want = replies_due.pop_front();
          if (got.verdict !== want.verdict) begin
            $error("verdict: expected %0d, got %0d", want.verdict, got.verdict);
            error_count++;
          end
          if (got.is4a !== want.is4a) begin
            $error("is_socks4a: expected %0d, got %0d", want.is4a, got.is4a);
            error_count++;
          end
          if (got.port !== want.port) begin
            $error("dest_port: expected %h, got %h", want.port, got.port);
            error_count++;
          end
          if (got.addr !== want.addr) begin
            $error("dest_ip: expected %h, got %h", want.addr, got.addr);
            error_count++;
          end
          if (got.user_len !== want.user_len) begin
            $error("userid_length: expected %0d, got %0d", want.user_len, got.user_len);
            error_count++;
          end
          if (got.host_len !== want.host_len) begin
            $error("hostname_length: expected %0d, got %0d", want.host_len, got.host_len);
            error_count++;
          end
        end
        out_hold = pick_gap(mon_calm);
        if ($urandom_range(0, 63) == 0) mon_calm = !mon_calm;
      end else if (out_hold > 0) begin
        out_hold--;
      end else if (!mon_calm && $urandom_range(0, 15) == 0) begin
        out_hold = pick_gap(1'b0);
      end
      out_tready <= (out_hold == 0);
    end
  end

  // Request building
  task automatic open_request(input logic [7:0] ver, input logic [7:0] cmd,
                              input logic [15:0] port, input logic [31:0] addr);
    build_q.delete();
    build_q.push_back(ver);
    build_q.push_back(cmd);
    build_q.push_back(port[15:8]);
    build_q.push_back(port[7:0]);
    build_q.push_back(addr[31:24]);
    build_q.push_back(addr[23:16]);
    build_q.push_back(addr[15:8]);
    build_q.push_back(addr[7:0]);
  endtask

  task automatic append_text(input int n);
    repeat (n) build_q.push_back(8'($urandom_range(1, 255)));
  endtask

  task automatic append_zero();
    build_q.push_back(8'h00);
  endtask

  // Hand the built request to the driver, flagging its last byte
  task automatic close_request();
    req_byte_t item;
    foreach (build_q[i]) begin
      item.data = build_q[i];
      item.last = (i == build_q.size() - 1);
      request_bytes_q.push_back(item);
    end
    build_q.delete();
  endtask

  // Mostly well-formed requests with random content; the rest broken or noise
  task automatic add_random_request();
    int          r;
    int          c;
    int          ulen;
    int          hlen;
    int          cut;
    logic [7:0]  cmd;
    logic [31:0] addr;
    r = $urandom_range(0, 99);
    if (r >= 96) begin
      build_q.delete();
      repeat ($urandom_range(1, 30)) begin
        if ($urandom_range(0, 9) < 3) append_zero();
        else append_text(1);
      end
      close_request();
      return;
    end
    c   = $urandom_range(0, 99);
    cmd = (c < 45) ? CMD_CONNECT : (c < 75) ? CMD_BIND : 8'($urandom);
    c   = $urandom_range(0, 99);
    addr = (c < 45) ? {24'h0, 8'($urandom_range(1, 255))} : (c < 50) ? 32'h0 : $urandom;
    c    = $urandom_range(0, 99);
    ulen = (c < 25) ? 0 : (c < 90) ? $urandom_range(1, 10) : $urandom_range(11, 60);
    hlen = $urandom_range(1, 20);
    if (r == 95) ulen = $urandom_range(248, 280);
    if (r == 93 || r == 94) hlen = 0;

    open_request(8'($urandom), cmd, 16'($urandom), addr);
    append_text(ulen);
    append_zero();
    if (addr[31:8] == 24'h0 && addr[7:0] != 8'h00) begin
      append_text(hlen);
      append_zero();
    end
    // Break the request in one of a few ways
    if (r >= 80 && r < 85) begin
      cut = $urandom_range(1, build_q.size() - 1);
      while (build_q.size() > cut) void'(build_q.pop_back());
    end else if (r >= 85 && r < 90) begin
      build_q[build_q.size() - 1] = 8'($urandom_range(1, 255));
    end else if (r >= 90 && r < 93) begin
      append_zero();
    end
    close_request();
  endtask

  // Hold until the block has drained every byte and result
  task automatic wait_idle();
    while (request_bytes_q.size() != 0 || in_tvalid || replies_due.size() != 0)
      @(posedge clk);
    repeat (LATENCY_PAD) @(posedge clk);
  endtask

  task automatic write_auth(input logic value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    auth_on = value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Stimulus sequence
  initial begin : stimulus
    logic auth_plan[4];
    int   start_bytes;
    int   reqs;
    auth_plan = '{1'b0, 1'b1, 1'b1, 1'b0};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests with authentication off
    write_auth(1'b0);
    open_request(8'h04, CMD_CONNECT, 16'h0050, 32'h01020304);
    append_text(3); append_zero(); close_request();
    open_request(8'h04, CMD_BIND, 16'hFFFF, 32'hFFFFFFFF);
    append_zero(); close_request();
    open_request(8'h04, 8'h00, 16'h0000, 32'h0A000001);
    append_text(1); append_zero(); close_request();
    open_request(8'h04, 8'hFF, 16'h1234, 32'h80000000);
    append_text(2); append_zero(); close_request();
    // 4a with a hostname
    open_request(8'h04, CMD_CONNECT, 16'h1F90, 32'h00000001);
    append_text(2); append_zero(); append_text(5); append_zero(); close_request();
    // 4a with an empty hostname
    open_request(8'h04, CMD_BIND, 16'h0015, 32'h000000FF);
    append_text(1); append_zero(); append_zero(); close_request();
    // 4a with only the userid terminator
    open_request(8'h04, CMD_CONNECT, 16'h0100, 32'h00000080);
    append_text(4); append_zero(); close_request();
    // 4a with a third zero
    open_request(8'h04, CMD_CONNECT, 16'h0101, 32'h00000002);
    append_text(1); append_zero(); append_text(2); append_zero(); append_zero();
    close_request();
    // Plain request carrying two zeros
    open_request(8'h04, CMD_CONNECT, 16'h0202, 32'hC0A80001);
    append_text(1); append_zero(); append_text(2); append_zero(); close_request();
    // All-zero address is plain, not 4a
    open_request(8'h04, CMD_CONNECT, 16'h0303, 32'h00000000);
    append_text(2); append_zero(); close_request();
    // No trailing zero
    open_request(8'h04, CMD_CONNECT, 16'h0404, 32'h05060708);
    append_text(3); build_q.push_back(8'h41); close_request();
    // Too short: eight bytes ending in zero, then a lone zero byte
    open_request(8'h04, CMD_CONNECT, 16'h0001, 32'h7F000000);
    close_request();
    build_q.push_back(8'h00); close_request();
    // Exactly the buffer size, then one byte over
    open_request(8'h04, CMD_CONNECT, 16'h0016, 32'h08080808);
    append_text(247); append_zero(); close_request();
    open_request(8'h04, CMD_CONNECT, 16'h0017, 32'h08080404);
    append_text(248); append_zero(); close_request();
    // 4a with empty userid and a long hostname
    open_request(8'h04, CMD_CONNECT, 16'h01BB, 32'h000000FF);
    append_zero(); append_text(30); append_zero(); close_request();
    wait_idle();

    // Directed requests with authentication on
    write_auth(1'b1);
    open_request(8'h04, CMD_CONNECT, 16'h0050, 32'h0B0C0D0E);
    append_zero(); close_request();
    open_request(8'h04, CMD_CONNECT, 16'h0051, 32'h0B0C0D0F);
    append_text(1); append_zero(); close_request();
    open_request(8'h04, CMD_BIND, 16'h0052, 32'h0B0C0D10);
    append_zero(); close_request();
    open_request(8'h04, 8'h7E, 16'h0053, 32'h0B0C0D11);
    append_zero(); close_request();
    open_request(8'h04, CMD_CONNECT, 16'h0050, 32'h00000005);
    append_zero(); append_text(3); append_zero(); close_request();
    open_request(8'h04, 8'h7E, 16'h0054, 32'h0B0C0D12);
    append_text(2); append_zero(); close_request();
    wait_idle();

    // Random phases, each with its own authentication setting
    foreach (auth_plan[p]) begin
      write_auth(auth_plan[p]);
      start_bytes = request_bytes_q.size();
      reqs = 0;
      while (request_bytes_q.size() - start_bytes < 30 || reqs < 2) begin
        add_random_request();
        reqs++;
      end
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Stop a hung run
  initial begin : watchdog
    #8000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> sim.f
design/s4a_pkg.sv
design/s4a_parse.sv
design/s4a_verdict.sv
design/socks4a_request_parser_unit.sv
sim/socks4a_request_parser_unit_tb.sv
